// File: hw/rtl/sopf_pkg.sv
package sopf_pkg;

   localparam int NUM_SLOTS_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int SLOT_W         = 6;
   localparam int TAG_W          = 16;
   localparam int FIELD_W        = 16;
   localparam int AXES           = 3;
   localparam int MAX_HITS       = 63;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_SWEEP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_A,
      ST_LOAD_A,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic                      req_type;
      logic [SLOT_W-1:0]         slot;
      logic [TAG_W-1:0]          entity_tag;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
      logic [FIELD_W-1:0]        radius;
      logic                      enabled;
      logic                      occupied;
   } req_beat_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot_a;
      logic [SLOT_W-1:0] slot_b;
      logic [TAG_W-1:0]  entity_a;
      logic [TAG_W-1:0]  entity_b;
      logic              last;
   } rsp_beat_type;

   // candidate B travelling down the compare chain
   typedef struct packed {
      logic              live;
      logic              ok;
      logic [SLOT_W-1:0] slot_b;
      logic [TAG_W-1:0]  entity_b;
   } cand_type;

endpackage

// File: hw/rtl/sopf_cell.sv
module sopf_cell #(
   parameter int COORD_BITS = sopf_pkg::COORD_BITS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  sopf_pkg::cand_type                                cand_in,
   input  logic [sopf_pkg::AXES-1:0][COORD_BITS:0]           diff_in,
   input  logic [2*(COORD_BITS+1)+1:0]                       sum_in,
   input  logic [2*(COORD_BITS+1)-1:0]                       rsq_in,
   output sopf_pkg::cand_type                                cand_out,
   output logic [sopf_pkg::AXES-1:0][COORD_BITS:0]           diff_out,
   output logic [2*(COORD_BITS+1)+1:0]                       sum_out,
   output logic [2*(COORD_BITS+1)-1:0]                       rsq_out
);

   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW + 2;

   logic signed [2*DW-1:0]           sq;
   sopf_pkg::cand_type               cand_ff;
   logic [sopf_pkg::AXES-1:0][DW-1:0] diff_ff, diff_in_shift;
   logic [SW-1:0]                    sum_ff, sum_in_acc;
   logic [2*DW-1:0]                  rsq_ff;

   // square the head axis and add it to the running distance
   assign sq            = $signed(diff_in[0]) * $signed(diff_in[0]);
   assign sum_in_acc    = sum_in + SW'(unsigned'(sq));
   assign diff_in_shift = {DW'(0), diff_in[sopf_pkg::AXES-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.live <= 1'b0;
      end else begin
         cand_ff.live <= cand_in.live;
      end
      cand_ff.ok       <= cand_in.ok;
      cand_ff.slot_b   <= cand_in.slot_b;
      cand_ff.entity_b <= cand_in.entity_b;
      diff_ff          <= diff_in_shift;
      sum_ff           <= sum_in_acc;
      rsq_ff           <= rsq_in;
   end

   assign cand_out = cand_ff;
   assign diff_out = diff_ff;
   assign sum_out  = sum_ff;
   assign rsq_out  = rsq_ff;

endmodule

// File: hw/rtl/sphere_overlap_pair_finder.sv
// Sphere collider table with an all-pairs overlap sweep.
// Request channel: a beat is taken when start is high and busy is low.
// A write beat stores or frees one slot and gives no result; busy stays low.
// A sweep beat names slot A and scans every later slot, one memory read per
// cycle, through a row of three cells that each square one axis difference
// and add it to the running distance. Each pair with both colliders enabled
// and distance squared below the radius sum squared gives one rsp beat, up to
// 63 per sweep; the final beat carries last. A sweep without hits gives one
// beat with hit low and last high.
// Timing: a sweep of a free or out-of-range slot answers in the next cycle
// and busy stays low; a disabled slot A answers once the busy states READ_A
// and LOAD_A have passed. Otherwise busy holds through READ_A, LOAD_A and
// SCAN until the slot scan and the read, prep, cell and compare stages have
// drained, and the final beat shows in the first cycle with busy low.
// Result beats show for one cycle on rsp_strobe; the receiver cannot stall.
// Reset clears all slot valid bits at once and returns to idle; the stored
// fields of a slot are defined only once the slot is written.
module sphere_overlap_pair_finder #(
   parameter int NUM_SLOTS  = sopf_pkg::NUM_SLOTS_DEF,
   parameter int COORD_BITS = sopf_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sopf_pkg::req_beat_type req_data,
   output logic                   rsp_strobe,
   output sopf_pkg::rsp_beat_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PTR_W = $clog2(NUM_SLOTS + (1 << sopf_pkg::SLOT_W)) + 1;
   localparam int DW    = COORD_BITS + 1;
   localparam int SW    = 2 * DW + 2;
   localparam int RW    = 2 * DW;
   localparam int AX    = sopf_pkg::AXES;
   localparam int SLW   = sopf_pkg::SLOT_W;
   localparam int CNT_W = $clog2(sopf_pkg::MAX_HITS + 1);

   // slot table
   logic signed [COORD_BITS-1:0]  mem_x [NUM_SLOTS];
   logic signed [COORD_BITS-1:0]  mem_y [NUM_SLOTS];
   logic signed [COORD_BITS-1:0]  mem_z [NUM_SLOTS];
   logic [COORD_BITS-1:0]         mem_rad [NUM_SLOTS];
   logic [sopf_pkg::TAG_W-1:0]    mem_ent [NUM_SLOTS];
   logic                          mem_en [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]          valid_ff;

   logic signed [COORD_BITS-1:0]  rd_x, rd_y, rd_z;
   logic [COORD_BITS-1:0]         rd_rad;
   logic [sopf_pkg::TAG_W-1:0]    rd_ent;
   logic                          rd_en;

   sopf_pkg::state_type           state_ff, state_in;
   logic [SLW-1:0]                slot_a_ff;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic signed [COORD_BITS-1:0]  a_x_ff, a_y_ff, a_z_ff;
   logic [COORD_BITS-1:0]         a_rad_ff;
   logic [sopf_pkg::TAG_W-1:0]    a_ent_ff;
   sopf_pkg::rsp_beat_type        pend_ff, pend_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   sopf_pkg::rsp_beat_type        rsp_ff, rsp_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;

   logic                          accept, in_range, wr_take, scan_issue, scan_done;
   logic [IDX_W-1:0]              req_idx, rd_idx, ptr_idx;
   sopf_pkg::rsp_beat_type        nohit;

   // pipeline
   sopf_pkg::cand_type            s1_ff, s2_ff, cmp_ff;
   logic [AX-1:0][DW-1:0]         s2_diff_ff;
   logic [RW-1:0]                 s2_rsq_ff;
   logic [DW-1:0]                 rsum;
   sopf_pkg::cand_type            c_cand [AX+1];
   logic [AX-1:0][DW-1:0]         c_diff [AX+1];
   logic [SW-1:0]                 c_sum [AX+1];
   logic [RW-1:0]                 c_rsq [AX+1];
   logic                          cmp_hit_ff;
   logic [AX-1:0]                 cell_live;

   assign busy     = (state_ff != sopf_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = PTR_W'(req_data.slot) < PTR_W'(NUM_SLOTS);
   assign req_idx  = IDX_W'(req_data.slot);
   assign wr_take  = accept && (req_data.req_type == sopf_pkg::REQ_WRITE) && in_range;
   assign ptr_idx  = IDX_W'(ptr_ff);
   assign rd_idx   = (state_ff == sopf_pkg::ST_READ_A) ? IDX_W'(slot_a_ff) : ptr_idx;
   assign scan_issue = (state_ff == sopf_pkg::ST_SCAN) && (ptr_ff < PTR_W'(NUM_SLOTS));

   // store a written slot
   always_ff @(posedge clock) begin
      if (wr_take && req_data.occupied) begin
         mem_x[req_idx]   <= COORD_BITS'(req_data.pos_x);
         mem_y[req_idx]   <= COORD_BITS'(req_data.pos_y);
         mem_z[req_idx]   <= COORD_BITS'(req_data.pos_z);
         mem_rad[req_idx] <= COORD_BITS'(req_data.radius);
         mem_ent[req_idx] <= req_data.entity_tag;
         mem_en[req_idx]  <= req_data.enabled;
      end
      rd_x   <= mem_x[rd_idx];
      rd_y   <= mem_y[rd_idx];
      rd_z   <= mem_z[rd_idx];
      rd_rad <= mem_rad[rd_idx];
      rd_ent <= mem_ent[rd_idx];
      rd_en  <= mem_en[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_take) begin
         valid_ff[req_idx] <= req_data.occupied;
      end
   end

   // issue stage and prep stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.live <= 1'b0;
         s2_ff.live <= 1'b0;
      end else begin
         s1_ff.live <= scan_issue;
         s2_ff.live <= s1_ff.live;
      end
      s1_ff.ok       <= valid_ff[ptr_idx];
      s1_ff.slot_b   <= SLW'(ptr_ff);
      s1_ff.entity_b <= '0;
      s2_ff.ok       <= s1_ff.ok && rd_en;
      s2_ff.slot_b   <= s1_ff.slot_b;
      s2_ff.entity_b <= rd_ent;
      s2_diff_ff[0]  <= DW'(a_x_ff) - DW'(rd_x);
      s2_diff_ff[1]  <= DW'(a_y_ff) - DW'(rd_y);
      s2_diff_ff[2]  <= DW'(a_z_ff) - DW'(rd_z);
      s2_rsq_ff      <= RW'(rsum) * RW'(rsum);
   end

   assign rsum = DW'(a_rad_ff) + DW'(rd_rad);

   // row of axis cells
   assign c_cand[0] = s2_ff;
   assign c_diff[0] = s2_diff_ff;
   assign c_sum[0]  = '0;
   assign c_rsq[0]  = s2_rsq_ff;

   for (genvar k = 0; k < AX; k++) begin : g_cell
      sopf_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cand_in  (c_cand[k]),
         .diff_in  (c_diff[k]),
         .sum_in   (c_sum[k]),
         .rsq_in   (c_rsq[k]),
         .cand_out (c_cand[k+1]),
         .diff_out (c_diff[k+1]),
         .sum_out  (c_sum[k+1]),
         .rsq_out  (c_rsq[k+1])
      );
      assign cell_live[k] = c_cand[k+1].live;
   end

   // compare distance against radius sum
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff.live <= 1'b0;
      end else begin
         cmp_ff.live <= c_cand[AX].live;
      end
      cmp_ff.ok       <= c_cand[AX].ok;
      cmp_ff.slot_b   <= c_cand[AX].slot_b;
      cmp_ff.entity_b <= c_cand[AX].entity_b;
      cmp_hit_ff      <= c_cand[AX].ok && (c_sum[AX] < SW'(c_rsq[AX]));
   end

   assign scan_done = !scan_issue && !s1_ff.live && !s2_ff.live && !(|cell_live)
                      && !cmp_ff.live;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sopf_pkg::ST_IDLE: begin
            if (accept && (req_data.req_type == sopf_pkg::REQ_SWEEP) && in_range
                && valid_ff[req_idx]) begin
               state_in = sopf_pkg::ST_READ_A;
            end
         end
         sopf_pkg::ST_READ_A: state_in = sopf_pkg::ST_LOAD_A;
         sopf_pkg::ST_LOAD_A: state_in = rd_en ? sopf_pkg::ST_SCAN : sopf_pkg::ST_IDLE;
         sopf_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = sopf_pkg::ST_IDLE;
            end
         end
         default: state_in = sopf_pkg::ST_IDLE;
      endcase
   end

   // outputs, hit holding and scan pointer
   always_comb begin
      nohit          = '0;
      nohit.slot_a   = slot_a_ff;
      nohit.entity_a = a_ent_ff;
      nohit.last     = 1'b1;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      case (state_ff)
         sopf_pkg::ST_IDLE: begin
            if (accept && (req_data.req_type == sopf_pkg::REQ_SWEEP)
                && !(in_range && valid_ff[req_idx])) begin
               rsp_strobe_in   = 1'b1;
               rsp_in          = '0;
               rsp_in.slot_a   = req_data.slot;
               rsp_in.last     = 1'b1;
            end
         end
         sopf_pkg::ST_READ_A: begin
            pend_valid_in = 1'b0;
            cnt_in        = '0;
         end
         sopf_pkg::ST_LOAD_A: begin
            ptr_in = PTR_W'(slot_a_ff) + PTR_W'(1);
            if (!rd_en) begin
               rsp_strobe_in   = 1'b1;
               rsp_in          = '0;
               rsp_in.slot_a   = slot_a_ff;
               rsp_in.entity_a = rd_ent;
               rsp_in.last     = 1'b1;
            end
         end
         sopf_pkg::ST_SCAN: begin
            if (scan_issue) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
            if (cmp_ff.live && cmp_hit_ff && (cnt_ff < CNT_W'(sopf_pkg::MAX_HITS))) begin
               // release the held hit, hold the new one
               rsp_strobe_in    = pend_valid_ff;
               rsp_in           = pend_ff;
               pend_in.hit      = 1'b1;
               pend_in.slot_a   = slot_a_ff;
               pend_in.slot_b   = cmp_ff.slot_b;
               pend_in.entity_a = a_ent_ff;
               pend_in.entity_b = cmp_ff.entity_b;
               pend_in.last     = 1'b0;
               pend_valid_in    = 1'b1;
               cnt_in           = cnt_ff + CNT_W'(1);
            end else if (scan_done) begin
               rsp_strobe_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = nohit;
               end
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sopf_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      ptr_ff  <= ptr_in;
      if (accept) begin
         slot_a_ff <= req_data.slot;
      end
      // latch slot A once its entry is read
      if (state_ff == sopf_pkg::ST_LOAD_A) begin
         a_x_ff   <= rd_x;
         a_y_ff   <= rd_y;
         a_z_ff   <= rd_z;
         a_rad_ff <= rd_rad;
         a_ent_ff <= rd_ent;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
